### hw/rtl/moving_average_linear_map_macros.svh
// Assertion macros for the moving average / linear map block.
// Used by the port checker; no other dependencies.
`ifndef MOVING_AVERAGE_LINEAR_MAP_MACROS_SVH
`define MOVING_AVERAGE_LINEAR_MAP_MACROS_SVH

// same-cycle implication
`define MAVG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MAVG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/mavg_pkg.sv
// Shared types and constants for the moving average / linear map block.
// No dependencies.
package mavg_pkg;

	localparam int CH_BITS  = 2;
	localparam int AVG_BITS = 12;
	localparam int MAP_BITS = 32;
	localparam int IN_BITS  = 12;
	localparam int OUT_BITS = 16;

	// serial divider: 32-bit dividend, 16-bit divisor, two quotient bits a cycle
	localparam int DIV_N     = 32;
	localparam int DIV_D     = 16;
	localparam int DIV_STEPS = 2;
	localparam int DIV_CNT_W = $clog2(DIV_N / DIV_STEPS);

	localparam int FIFO_DEPTH = 2;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	typedef enum logic [2:0] {
		REG_SP_IN_LOW   = 3'd0,
		REG_SP_IN_HIGH  = 3'd1,
		REG_SP_OUT_LOW  = 3'd2,
		REG_SP_OUT_HIGH = 3'd3,
		REG_FB_IN_LOW   = 3'd4,
		REG_FB_IN_HIGH  = 3'd5,
		REG_FB_OUT_LOW  = 3'd6,
		REG_FB_OUT_HIGH = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic        [IN_BITS-1:0]  sp_in_low;
		logic        [IN_BITS-1:0]  sp_in_high;
		logic signed [OUT_BITS-1:0] sp_out_low;
		logic signed [OUT_BITS-1:0] sp_out_high;
		logic        [IN_BITS-1:0]  fb_in_low;
		logic        [IN_BITS-1:0]  fb_in_high;
		logic signed [OUT_BITS-1:0] fb_out_low;
		logic signed [OUT_BITS-1:0] fb_out_high;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		sp_in_low:   12'd0,
		sp_in_high:  12'd2800,
		sp_out_low:  -16'sd7000,
		sp_out_high: 16'sd7000,
		fb_in_low:   12'd700,
		fb_in_high:  12'd1900,
		fb_out_low:  -16'sd8000,
		fb_out_high: 16'sd8000
	};

	typedef struct packed {
		logic             start;
		logic [DIV_N-1:0] dividend;
		logic [DIV_D-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_N-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [1:0] {
		F_CLEAR,
		F_IDLE,
		F_UPDATE
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_SPAN,
		B_MAP,
		B_DONE
	} back_state_t;

endpackage

### hw/rtl/mavg_if.sv
// Sample and result channel interfaces (valid/ready).
// Depends on mavg_pkg.
interface mavg_in_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                          valid;
	logic                          ready;
	logic [mavg_pkg::CH_BITS-1:0]  channel;
	logic [SAMPLE_BITS-1:0]        sample;

	modport source (output valid, channel, sample, input ready);
	modport sink (input valid, channel, sample, output ready);
endinterface

interface mavg_out_if;
	logic                                valid;
	logic                                ready;
	logic        [mavg_pkg::CH_BITS-1:0]  channel_out;
	logic        [mavg_pkg::AVG_BITS-1:0] average;
	logic signed [mavg_pkg::MAP_BITS-1:0] mapped;
	logic                                bad_span;

	modport source (output valid, channel_out, average, mapped, bad_span, input ready);
	modport sink (input valid, channel_out, average, mapped, bad_span, output ready);
endinterface

### hw/rtl/moving_average_linear_map.sv
// Samples pass the front part (ring update), a two-entry queue and the back
// part (serial span divide and map); the divide is skipped when the input span is zero.
// The front can take a new sample while the back part still works on an earlier
// one, until the queue is full.
// Reset: asynchronous, active low; configuration returns to defaults and the
// sample rings are zeroed by a clearing pass over all CHANNELS*WINDOW entries
// (20 by default), during which no sample is taken.
module moving_average_linear_map #(
	parameter int WINDOW = 5,
	parameter int CHANNELS = 4,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mavg_in_if.sink                       samples,
	mavg_out_if.source                    results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mavg_pkg::PADDR_W-1:0]  paddr,
	input  logic [mavg_pkg::PDATA_W-1:0]  pwdata,
	output logic [mavg_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	localparam int SUM_W = SAMPLE_BITS + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
	localparam int Q_W   = mavg_pkg::CH_BITS + SUM_W;
	localparam int DW    = mavg_pkg::PDATA_W;

	mavg_pkg::cfg_t   cfg_q;
	mavg_pkg::reg_idx_t reg_idx;

	logic                         q_push_valid;
	logic                         q_push_ready;
	logic [mavg_pkg::CH_BITS-1:0] q_push_channel;
	logic [SUM_W-1:0]             q_push_sum;
	logic                         q_pop_valid;
	logic                         q_pop_ready;
	logic [Q_W-1:0]               q_pop_data;

	assign pready  = 1'b1;
	assign reg_idx = mavg_pkg::reg_idx_t'(paddr[mavg_pkg::PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= mavg_pkg::CFG_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				mavg_pkg::REG_SP_IN_LOW:   cfg_q.sp_in_low   <= pwdata[mavg_pkg::IN_BITS-1:0];
				mavg_pkg::REG_SP_IN_HIGH:  cfg_q.sp_in_high  <= pwdata[mavg_pkg::IN_BITS-1:0];
				mavg_pkg::REG_SP_OUT_LOW:  cfg_q.sp_out_low  <= pwdata[mavg_pkg::OUT_BITS-1:0];
				mavg_pkg::REG_SP_OUT_HIGH: cfg_q.sp_out_high <= pwdata[mavg_pkg::OUT_BITS-1:0];
				mavg_pkg::REG_FB_IN_LOW:   cfg_q.fb_in_low   <= pwdata[mavg_pkg::IN_BITS-1:0];
				mavg_pkg::REG_FB_IN_HIGH:  cfg_q.fb_in_high  <= pwdata[mavg_pkg::IN_BITS-1:0];
				mavg_pkg::REG_FB_OUT_LOW:  cfg_q.fb_out_low  <= pwdata[mavg_pkg::OUT_BITS-1:0];
				mavg_pkg::REG_FB_OUT_HIGH: cfg_q.fb_out_high <= pwdata[mavg_pkg::OUT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mavg_pkg::REG_SP_IN_LOW:   prdata = DW'(cfg_q.sp_in_low);
			mavg_pkg::REG_SP_IN_HIGH:  prdata = DW'(cfg_q.sp_in_high);
			mavg_pkg::REG_SP_OUT_LOW:  prdata = DW'($unsigned(cfg_q.sp_out_low));
			mavg_pkg::REG_SP_OUT_HIGH: prdata = DW'($unsigned(cfg_q.sp_out_high));
			mavg_pkg::REG_FB_IN_LOW:   prdata = DW'(cfg_q.fb_in_low);
			mavg_pkg::REG_FB_IN_HIGH:  prdata = DW'(cfg_q.fb_in_high);
			mavg_pkg::REG_FB_OUT_LOW:  prdata = DW'($unsigned(cfg_q.fb_out_low));
			mavg_pkg::REG_FB_OUT_HIGH: prdata = DW'($unsigned(cfg_q.fb_out_high));
			default:                   prdata = '0;
		endcase
	end

	mavg_front #(
		.WINDOW      (WINDOW),
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.samples      (samples),
		.push_valid   (q_push_valid),
		.push_ready   (q_push_ready),
		.push_channel (q_push_channel),
		.push_sum     (q_push_sum)
	);

	mavg_fifo #(
		.WIDTH (Q_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  ({q_push_channel, q_push_sum}),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	mavg_back #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pop_valid   (q_pop_valid),
		.pop_ready   (q_pop_ready),
		.pop_channel (q_pop_data[Q_W-1:SUM_W]),
		.pop_sum     (q_pop_data[SUM_W-1:0]),
		.results     (results)
	);

endmodule

### hw/rtl/mavg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mavg_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 20,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/mavg_fifo.sv
// Two-entry queue between the front (ring update) and back (divide/map) parts.
// Depends on mavg_pkg.
module mavg_fifo #(
	parameter int WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int CNT_W = $clog2(mavg_pkg::FIFO_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [mavg_pkg::FIFO_DEPTH];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != CNT_W'(mavg_pkg::FIFO_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hw/rtl/mavg_div.sv
// Serial restoring divider, unsigned, two quotient bits per cycle.
// Depends on mavg_pkg.
module mavg_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mavg_pkg::div_req_t req,
	output mavg_pkg::div_rsp_t rsp
);

	localparam int N = mavg_pkg::DIV_N;
	localparam int D = mavg_pkg::DIV_D;
	localparam int CW = mavg_pkg::DIV_CNT_W;

	logic [D-1:0]  rem_q;
	logic [N-1:0]  quo_q;
	logic [D-1:0]  den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [D-1:0]  rem_nx;
	logic [N-1:0]  quo_nx;

	always_comb begin
		logic [D:0] t;
		rem_nx = rem_q;
		quo_nx = quo_q;
		for (int i = 0; i < mavg_pkg::DIV_STEPS; i++) begin
			t      = {rem_nx, quo_nx[N-1]};
			quo_nx = {quo_nx[N-2:0], 1'b0};
			if (t >= {1'b0, den_q}) begin
				t         = t - {1'b0, den_q};
				quo_nx[0] = 1'b1;
			end
			rem_nx = t[D-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == {CW{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

### hw/rtl/mavg_front.sv
// Front part: takes samples, updates the per-channel ring, running sum and
// write position, and queues the new sum. Depends on mavg_pkg, mavg_if, mavg_ram.
module mavg_front #(
	parameter int WINDOW = 5,
	parameter int CHANNELS = 4,
	parameter int SAMPLE_BITS = 12,
	localparam int SUM_W = SAMPLE_BITS + ((WINDOW > 1) ? $clog2(WINDOW) : 0)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mavg_in_if.sink                       samples,
	output logic                          push_valid,
	input  logic                          push_ready,
	output logic [mavg_pkg::CH_BITS-1:0]  push_channel,
	output logic [SUM_W-1:0]              push_sum
);

	localparam int DEPTH  = CHANNELS * WINDOW;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	mavg_pkg::front_state_t st_q, st_nx;

	logic [SUM_W-1:0]             sum_q [CHANNELS];
	logic [POS_W-1:0]             wpos_q [CHANNELS];
	logic [ADDR_W-1:0]            clr_q;
	logic [mavg_pkg::CH_BITS-1:0] ch_q;
	logic [IDX_W-1:0]             idx_q;
	logic [POS_W-1:0]             cur_pos_q;
	logic [SAMPLE_BITS-1:0]       smp_q;
	logic [ADDR_W-1:0]            addr_q;

	logic [mavg_pkg::CH_BITS-1:0] ch_mod;
	logic [IDX_W-1:0]             in_idx;
	logic [ADDR_W-1:0]            in_addr;
	logic                         accept;
	logic                         commit;
	logic [SAMPLE_BITS-1:0]       old_smp;
	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_waddr;
	logic [SAMPLE_BITS-1:0]       ram_wdata;
	logic [POS_W-1:0]             next_pos;

	// channel number folded onto the channels that have state
	always_comb begin
		ch_mod = samples.channel;
		for (int k = 0; k < 3; k++) begin
			if (int'(ch_mod) >= CHANNELS) begin
				ch_mod = ch_mod - mavg_pkg::CH_BITS'(CHANNELS);
			end
		end
		in_idx  = IDX_W'(ch_mod);
		in_addr = ADDR_W'(int'(in_idx) * WINDOW + int'(wpos_q[in_idx]));
	end

	assign accept   = samples.valid && samples.ready;
	assign next_pos = (cur_pos_q == POS_W'(WINDOW - 1)) ? '0 : cur_pos_q + POS_W'(1);
	assign push_channel = ch_q;
	assign push_sum = sum_q[idx_q] - SUM_W'(old_smp) + SUM_W'(smp_q);

	always_comb begin
		st_nx         = st_q;
		samples.ready = 1'b0;
		push_valid    = 1'b0;
		commit        = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = addr_q;
		ram_wdata     = smp_q;
		case (st_q)
			mavg_pkg::F_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					st_nx = mavg_pkg::F_IDLE;
				end
			end
			mavg_pkg::F_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					st_nx = mavg_pkg::F_UPDATE;
				end
			end
			mavg_pkg::F_UPDATE: begin
				push_valid = 1'b1;
				if (push_ready) begin
					commit = 1'b1;
					ram_we = 1'b1;
					st_nx  = mavg_pkg::F_IDLE;
				end
			end
			default: st_nx = mavg_pkg::F_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= mavg_pkg::F_CLEAR;
			clr_q <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				sum_q[c]  <= '0;
				wpos_q[c] <= '0;
			end
		end else begin
			st_q <= st_nx;
			if (st_q == mavg_pkg::F_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (commit) begin
				sum_q[idx_q]  <= push_sum;
				wpos_q[idx_q] <= next_pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q      <= samples.channel;
			idx_q     <= in_idx;
			cur_pos_q <= wpos_q[in_idx];
			smp_q     <= samples.sample;
			addr_q    <= in_addr;
		end
	end

	// read of the oldest entry is issued with the accept; data is there in F_UPDATE
	mavg_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.wr_en (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.rd_en (accept),
		.raddr (in_addr),
		.rdata (old_smp)
	);

endmodule

### hw/rtl/mavg_back.sv
// Back part: divides the window sum, rescales and saturates the average (the low output
// bound on a zero input span), holds the result. Depends on mavg_pkg, mavg_if, mavg_div.
module mavg_back #(
	parameter int WINDOW = 5,
	parameter int SAMPLE_BITS = 12,
	localparam int SUM_W = SAMPLE_BITS + ((WINDOW > 1) ? $clog2(WINDOW) : 0)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mavg_pkg::cfg_t                cfg,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  logic [mavg_pkg::CH_BITS-1:0]  pop_channel,
	input  logic [SUM_W-1:0]              pop_sum,
	mavg_out_if.source                    results
);

	localparam int IB     = mavg_pkg::IN_BITS;
	localparam int OB     = mavg_pkg::OUT_BITS;
	localparam int MB     = mavg_pkg::MAP_BITS;
	localparam int DIFF_W = ((SAMPLE_BITS > IB) ? SAMPLE_BITS : IB) + 1;
	localparam int DOUT_W = OB + 1;
	localparam int PROD_W = DIFF_W + DOUT_W;
	localparam int SPAN_W = IB + 1;
	localparam int RES_W  = mavg_pkg::DIV_N + 2;
	// sum / WINDOW as (sum * ceil(2^REC_SH / WINDOW)) >> REC_SH, exact for any SUM_W-bit sum
	localparam int REC_SH = SUM_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
	localparam int AVGP_W = 2 * SUM_W + 1;
	localparam logic [AVGP_W-1:0] REC_M =
		AVGP_W'(((64'd1 << REC_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	mavg_pkg::back_state_t st_q, st_nx;
	mavg_pkg::div_req_t    div_req;
	mavg_pkg::div_rsp_t    div_rsp;

	logic [mavg_pkg::CH_BITS-1:0]  ch_q;
	logic [SAMPLE_BITS-1:0]        avg_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [SPAN_W-1:0]      span_q;
	logic                          neg_q;
	logic                          bad_q;
	logic [MB-1:0]                 map_q;
	logic                          out_vld_q;
	logic [mavg_pkg::CH_BITS-1:0]  out_ch_q;
	logic [mavg_pkg::AVG_BITS-1:0] out_avg_q;
	logic [MB-1:0]                 out_map_q;
	logic                          out_bad_q;

	logic [AVGP_W-1:0]        avg_prod;
	logic [SAMPLE_BITS-1:0]   avg_nx;
	logic [IB-1:0]            in_lo;
	logic [IB-1:0]            in_hi;
	logic signed [OB-1:0]     out_lo;
	logic signed [OB-1:0]     out_hi;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DOUT_W-1:0] dout;
	logic signed [PROD_W-1:0] prod;
	logic signed [SPAN_W-1:0] span;
	logic [PROD_W-1:0]        prod_abs;
	logic [SPAN_W-1:0]        span_abs;
	logic                     bad;
	logic signed [RES_W-1:0]  qext;
	logic signed [RES_W-1:0]  res;
	logic [RES_W-MB:0]        res_top;
	logic [MB-1:0]            sat;
	logic [MB-1:0]            lo_ext;
	logic                     load;

	// odd channels take the feedback range set
	always_comb begin
		if (ch_q[0]) begin
			in_lo  = cfg.fb_in_low;
			in_hi  = cfg.fb_in_high;
			out_lo = cfg.fb_out_low;
			out_hi = cfg.fb_out_high;
		end else begin
			in_lo  = cfg.sp_in_low;
			in_hi  = cfg.sp_in_high;
			out_lo = cfg.sp_out_low;
			out_hi = cfg.sp_out_high;
		end
	end

	always_comb begin
		avg_prod = AVGP_W'(pop_sum) * REC_M;
		avg_nx   = avg_prod[REC_SH +: SAMPLE_BITS];
		diff     = $signed(DIFF_W'(avg_q)) - $signed(DIFF_W'(in_lo));
		dout     = $signed({out_hi[OB-1], out_hi}) - $signed({out_lo[OB-1], out_lo});
		prod     = diff * dout;
		span     = $signed({1'b0, in_hi}) - $signed({1'b0, in_lo});
		prod_abs = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
		span_abs = span_q[SPAN_W-1] ? SPAN_W'(-span_q) : SPAN_W'(span_q);
		bad      = (span_q == '0);
		lo_ext   = {{(MB - OB){out_lo[OB-1]}}, out_lo};
		// quotient magnitude, sign restored: truncation toward zero
		qext     = $signed({2'b00, div_rsp.quotient});
		res      = (neg_q ? -qext : qext) + $signed({{(RES_W - OB){out_lo[OB-1]}}, out_lo});
		res_top  = res[RES_W-1:MB-1];
		if (&res_top || ~|res_top) begin
			sat = res[MB-1:0];
		end else if (res[RES_W-1]) begin
			sat = {1'b1, {(MB - 1){1'b0}}};
		end else begin
			sat = {1'b0, {(MB - 1){1'b1}}};
		end
	end

	always_comb begin
		st_nx            = st_q;
		pop_ready        = 1'b0;
		load             = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = mavg_pkg::DIV_N'(prod_abs);
		div_req.divisor  = mavg_pkg::DIV_D'(span_abs);
		case (st_q)
			mavg_pkg::B_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					st_nx = mavg_pkg::B_MUL;
				end
			end
			mavg_pkg::B_MUL: st_nx = mavg_pkg::B_SPAN;
			mavg_pkg::B_SPAN: begin
				if (bad) begin
					st_nx = mavg_pkg::B_DONE;
				end else begin
					div_req.start = 1'b1;
					st_nx         = mavg_pkg::B_MAP;
				end
			end
			mavg_pkg::B_MAP: begin
				if (div_rsp.done) begin
					st_nx = mavg_pkg::B_DONE;
				end
			end
			mavg_pkg::B_DONE: begin
				if (!out_vld_q || results.ready) begin
					load  = 1'b1;
					st_nx = mavg_pkg::B_IDLE;
				end
			end
			default: st_nx = mavg_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= mavg_pkg::B_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			mavg_pkg::B_IDLE: begin
				if (pop_valid) begin
					ch_q  <= pop_channel;
					avg_q <= avg_nx;
				end
			end
			mavg_pkg::B_MUL: begin
				prod_q <= prod;
				span_q <= span;
			end
			mavg_pkg::B_SPAN: begin
				neg_q <= prod_q[PROD_W-1] ^ span_q[SPAN_W-1];
				bad_q <= bad;
				map_q <= lo_ext;
			end
			mavg_pkg::B_MAP: begin
				if (div_rsp.done) begin
					map_q <= sat;
				end
			end
			default: begin
			end
		endcase
		if (load) begin
			out_ch_q  <= ch_q;
			out_avg_q <= mavg_pkg::AVG_BITS'(avg_q);
			out_map_q <= map_q;
			out_bad_q <= bad_q;
		end
	end

	assign results.valid       = out_vld_q;
	assign results.channel_out = out_ch_q;
	assign results.average     = out_avg_q;
	assign results.mapped      = $signed(out_map_q);
	assign results.bad_span    = out_bad_q;

	mavg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

### hw/rtl/mavg_checker.sv
// Port-level checker for moving_average_linear_map, bound to the top level.
// Depends on moving_average_linear_map_macros.svh.
`include "moving_average_linear_map_macros.svh"

module mavg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_channel,
	input logic [11:0] out_average,
	input logic [31:0] out_mapped,
	input logic        out_bad_span
);

	// front, queue, back and output register together hold at most five
	localparam logic [3:0] PEND_MAX = 4'd5;

	logic [3:0] pend_q;
	logic       in_fire;
	logic       out_fire;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_fire && !out_fire) begin
			pend_q <= pend_q + 4'd1;
		end else if (out_fire && !in_fire) begin
			pend_q <= pend_q - 4'd1;
		end
	end

	`MAVG_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`MAVG_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_channel) && $stable(out_average) && $stable(out_mapped) && $stable(out_bad_span), "result changed while stalled")
	`MAVG_ASSERT_IMP(a_no_phantom, clk, arst_n, out_fire, pend_q != 4'd0, "result with no sample outstanding")
	`MAVG_ASSERT_IMP(a_pend_bound, clk, arst_n, 1'b1, pend_q <= PEND_MAX, "too many samples in flight")
	`MAVG_ASSERT_IMP(a_bad_span_range, clk, arst_n, out_valid && out_bad_span, out_mapped[31:15] == 17'h00000 || out_mapped[31:15] == 17'h1ffff, "zero span result outside output range")

endmodule

bind moving_average_linear_map mavg_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (samples.valid),
	.in_ready     (samples.ready),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.out_channel  (results.channel_out),
	.out_average  (results.average),
	.out_mapped   (results.mapped),
	.out_bad_span (results.bad_span)
);
